/* design/stdf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package stdf_pkg;

  localparam int MAX_STATIONS  = 64;
  localparam int HISTORY_DEPTH = 8;
  localparam int ALLOW_SLOTS   = 3;

  localparam int STA_W  = $clog2(MAX_STATIONS);
  localparam int HPTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HIDX_W = $clog2(MAX_STATIONS * HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);

  // older trigger modes
  localparam logic [1:0] OMODE_REJECT = 2'd0;
  localparam logic [1:0] OMODE_LIMIT  = 2'd1;
  localparam logic [1:0] OMODE_ACCEPT = 2'd2;

  // register indexes
  localparam logic [2:0] REG_TOL     = 3'd0;
  localparam logic [2:0] REG_MODE    = 3'd1;
  localparam logic [2:0] REG_LIMIT   = 3'd2;
  localparam logic [2:0] REG_HIST    = 3'd3;
  localparam logic [2:0] REG_ACOUNT  = 3'd4;
  localparam logic [2:0] REG_ALLOW_A = 3'd5;
  localparam logic [2:0] REG_ALLOW_B = 3'd6;
  localparam logic [2:0] REG_ALLOW_C = 3'd7;

  localparam logic [2:0] V_NEW       = 3'd0;
  localparam logic [2:0] V_UNTRACKED = 3'd1;
  localparam logic [2:0] V_ON_PASS   = 3'd2;
  localparam logic [2:0] V_OFF_MATCH = 3'd3;
  localparam logic [2:0] V_COMP_REJ  = 3'd4;
  localparam logic [2:0] V_OFF_NONE  = 3'd5;
  localparam logic [2:0] V_DUP       = 3'd6;
  localparam logic [2:0] V_OLD       = 3'd7;

  typedef struct packed {
    logic [39:0] site_code;
    logic [15:0] net_code;
    logic [23:0] comp_code;
    logic [15:0] loc_code;
    logic [43:0] time_on_ms;
    logic [43:0] time_off_ms;
    logic [31:0] trig_seq;
    logic [31:0] eta_at_on;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRCH, ST_SRCH_W, ST_DECIDE, ST_SLOAD, ST_HRD, ST_HCHK,
    ST_OLDER, ST_COMMIT, ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture item
    logic srch_rd;    // read station index
    logic new_sta;    // install new station
    logic sta_rd;     // read station record
    logic hist_rd;    // read history entry
    logic hist_adv;   // next history index
    logic off_write;  // store off time
    logic on_commit;  // store on entry
    logic set_verdict;
    logic [2:0] verdict;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic comp_ok;
    logic is_off;
    logic srch_done;
    logic key_hit;
    logic sta_valid;
    logic have_free;
    logic hist_done;
    logic off_match;
    logic dup;
    logic too_old;
  } stat_t;

endpackage

`default_nettype wire

/* design/station_trigger_dedup_filter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Station trigger duplicate filter. Each report on s_axis gives one verdict word on m_axis.
// One report is in work at a time. The station table is searched one registered entry per
// cycle over up to 64 stations, stopping at a key hit; then a known station's history is
// read from its memory one entry at a time (up to 8 entries), each through the states
// ST_SLOAD, ST_HRD and ST_HCHK, followed by decision and write-back. A verdict word waiting
// on m_axis holds off the next report until it is accepted. Configuration must be written
// through cfg_we / cfg_addr / cfg_wdata only while the block is idle; the block itself does
// not enforce this.
module station_trigger_dedup_filter (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // site_code[39:0], net_code[55:40], comp_code[79:56], loc_code[95:80],
  // time_on_ms[139:96], time_off_ms[183:140], trig_seq[215:184], eta_at_on[247:216]
  input  wire  [247:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // pass_flag[0], verdict[3:1]
  output logic [7:0]   m_axis_tdata,
  input  wire          cfg_we,
  input  wire  [2:0]   cfg_addr,
  input  wire  [31:0]  cfg_wdata
);

  stdf_pkg::item_t in_item;
  stdf_pkg::cmd_t  cmd;
  stdf_pkg::stat_t stat;
  logic            out_busy, res_valid;
  logic [2:0]      res_verdict;

  assign in_item = '{s_axis_tdata[39:0], s_axis_tdata[55:40], s_axis_tdata[79:56],
                     s_axis_tdata[95:80], s_axis_tdata[139:96], s_axis_tdata[183:140],
                     s_axis_tdata[215:184], s_axis_tdata[247:216]};

  stdf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .out_busy(out_busy),
    .stat(stat), .in_ready(s_axis_tready), .cmd(cmd)
  );

  stdf_dp u_dp (
    .clk(clk), .rst(rst), .in_item(in_item), .cmd(cmd), .cfg_we(cfg_we),
    .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata), .out_take(m_axis_tready),
    .stat(stat), .out_busy(out_busy), .res_valid(res_valid), .res_verdict(res_verdict)
  );

  // result word
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {4'd0, res_verdict, (res_verdict <= stdf_pkg::V_OFF_MATCH)};

endmodule

`default_nettype wire

/* design/stdf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module stdf_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  out_busy,
  input  stdf_pkg::stat_t      stat,
  output logic                 in_ready,
  output stdf_pkg::cmd_t       cmd
);

  stdf_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= stdf_pkg::ST_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      stdf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = stdf_pkg::ST_SRCH;
        end
      end
      stdf_pkg::ST_SRCH: begin
        if (!stat.comp_ok) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict = stdf_pkg::V_COMP_REJ;
          state_next = stdf_pkg::ST_OUT;
        end else begin
          cmd.srch_rd = 1'b1;
          state_next = stdf_pkg::ST_SRCH_W;
        end
      end
      stdf_pkg::ST_SRCH_W: begin
        // one registered station record is checked per cycle
        if (stat.sta_valid && stat.key_hit) begin
          cmd.sta_rd = 1'b1;
          state_next = stdf_pkg::ST_SLOAD;
        end else if (stat.srch_done) begin
          state_next = stdf_pkg::ST_DECIDE;
        end else begin
          cmd.srch_rd = 1'b1;
        end
      end
      stdf_pkg::ST_DECIDE: begin
        cmd.set_verdict = 1'b1;
        if (stat.have_free) begin
          cmd.new_sta = 1'b1;
          cmd.verdict = stdf_pkg::V_NEW;
        end else begin
          cmd.verdict = stdf_pkg::V_UNTRACKED;
        end
        state_next = stdf_pkg::ST_OUT;
      end
      stdf_pkg::ST_SLOAD: begin
        if (stat.hist_done) begin
          state_next = stdf_pkg::ST_HCHK;
        end else begin
          cmd.hist_rd = 1'b1;
          state_next = stdf_pkg::ST_HRD;
        end
      end
      stdf_pkg::ST_HRD: state_next = stdf_pkg::ST_HCHK;
      stdf_pkg::ST_HCHK: begin
        if (stat.is_off) begin
          if (!stat.hist_done && stat.off_match) begin
            cmd.off_write = 1'b1;
            cmd.set_verdict = 1'b1;
            cmd.verdict = stdf_pkg::V_OFF_MATCH;
            state_next = stdf_pkg::ST_OUT;
          end else if (stat.hist_done) begin
            cmd.set_verdict = 1'b1;
            cmd.verdict = stdf_pkg::V_OFF_NONE;
            state_next = stdf_pkg::ST_OUT;
          end else begin
            cmd.hist_adv = 1'b1;
            state_next = stdf_pkg::ST_SLOAD;
          end
        end else begin
          if (!stat.hist_done && stat.dup) begin
            cmd.set_verdict = 1'b1;
            cmd.verdict = stdf_pkg::V_DUP;
            state_next = stdf_pkg::ST_OUT;
          end else if (stat.hist_done) begin
            state_next = stdf_pkg::ST_OLDER;
          end else begin
            cmd.hist_adv = 1'b1;
            state_next = stdf_pkg::ST_SLOAD;
          end
        end
      end
      stdf_pkg::ST_OLDER: begin
        cmd.set_verdict = 1'b1;
        if (stat.too_old) begin
          cmd.verdict = stdf_pkg::V_OLD;
          state_next = stdf_pkg::ST_OUT;
        end else begin
          cmd.verdict = stdf_pkg::V_ON_PASS;
          state_next = stdf_pkg::ST_COMMIT;
        end
      end
      stdf_pkg::ST_COMMIT: begin
        cmd.on_commit = 1'b1;
        state_next = stdf_pkg::ST_OUT;
      end
      stdf_pkg::ST_OUT: begin
        // wait for the result slot to be free
        if (!out_busy) state_next = stdf_pkg::ST_IDLE;
      end
      default: state_next = stdf_pkg::ST_IDLE;
    endcase
  end

  // only one store write per cycle
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.new_sta && cmd.on_commit) && !(cmd.off_write && cmd.on_commit))
    else $error("two store writes in one cycle");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == stdf_pkg::ST_IDLE))
    else $error("ready outside idle");
  a_load_srch: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == stdf_pkg::ST_SRCH))
    else $error("load not followed by search");

endmodule

`default_nettype wire

/* design/stdf_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module stdf_dp (
  input  wire                  clk,
  input  wire                  rst,
  input  stdf_pkg::item_t      in_item,
  input  stdf_pkg::cmd_t       cmd,
  input  wire                  cfg_we,
  input  wire  [2:0]           cfg_addr,
  input  wire  [31:0]          cfg_wdata,
  input  wire                  out_take,
  output stdf_pkg::stat_t      stat,
  output logic                 out_busy,
  output logic                 res_valid,
  output logic [2:0]           res_verdict
);

  localparam int SW = stdf_pkg::STA_W;
  localparam int PW = stdf_pkg::HPTR_W;
  localparam int CW = stdf_pkg::CNT_W;
  localparam int HW = stdf_pkg::HIDX_W;
  localparam logic [CW-1:0] DEPTH_MAX = CW'(stdf_pkg::HISTORY_DEPTH);

  // configuration
  logic [31:0] tol, olim;
  logic [1:0]  omode, acount;
  logic [3:0]  hused;
  logic [23:0] allow [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0; olim <= '0; omode <= '0; acount <= '0; hused <= 4'd8;
      allow[0] <= '0; allow[1] <= '0; allow[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        stdf_pkg::REG_TOL:     tol <= cfg_wdata;
        stdf_pkg::REG_MODE:    omode <= cfg_wdata[1:0];
        stdf_pkg::REG_LIMIT:   olim <= cfg_wdata;
        stdf_pkg::REG_HIST:    hused <= cfg_wdata[3:0];
        stdf_pkg::REG_ACOUNT:  acount <= cfg_wdata[1:0];
        stdf_pkg::REG_ALLOW_A: allow[0] <= cfg_wdata[23:0];
        stdf_pkg::REG_ALLOW_B: allow[1] <= cfg_wdata[23:0];
        stdf_pkg::REG_ALLOW_C: allow[2] <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // effective history length
  logic [CW-1:0] depth;
  always_comb begin
    if (hused == 4'd0) depth = CW'(1);
    else if ({{CW{1'b0}}, hused} > {4'd0, DEPTH_MAX}) depth = DEPTH_MAX;
    else depth = CW'(hused);
  end

  // captured item
  stdf_pkg::item_t it;
  always_ff @(posedge clk) if (cmd.load) it <= in_item;
  wire [55:0] key = {it.site_code, it.net_code};

  // allow list
  logic comp_ok;
  always_comb begin
    comp_ok = (acount == 2'd0);
    for (int i = 0; i < 3; i++)
      if (i < stdf_pkg::ALLOW_SLOTS && 2'(i) < acount && allow[i] == it.comp_code)
        comp_ok = 1'b1;
  end

  // station table
  logic [stdf_pkg::MAX_STATIONS-1:0] sval;
  logic [55:0]   skey [stdf_pkg::MAX_STATIONS];
  logic [43:0]   syoung [stdf_pkg::MAX_STATIONS];
  logic [CW-1:0] sfill [stdf_pkg::MAX_STATIONS];
  logic [PW-1:0] sptr [stdf_pkg::MAX_STATIONS];

  logic [SW:0]   scnt;
  logic [SW-1:0] sidx, cur_sta, free_sta;
  logic          have_free, srch_last;
  logic          rd_valid;
  logic [55:0]   rd_key;
  logic [43:0]   young;
  logic [CW-1:0] fill;
  logic [PW-1:0] wptr;

  // write pointer wrapped to the current length
  logic [PW-1:0] wptr_c;
  assign wptr_c = ({{(CW > PW ? CW-PW : 0){1'b0}}, wptr} >= depth) ? '0 : wptr;

  // search counter and registered station read
  always_ff @(posedge clk) begin
    if (cmd.load) scnt <= '0;
    else if (cmd.srch_rd) scnt <= scnt + 1'b1;
    if (rst) rd_valid <= 1'b0;
    else if (cmd.srch_rd) rd_valid <= sval[scnt[SW-1:0]];
    if (cmd.srch_rd) begin
      sidx <= scnt[SW-1:0];
      srch_last <= (scnt == (SW+1)'(stdf_pkg::MAX_STATIONS - 1));
      rd_key <= skey[scnt[SW-1:0]];
    end
  end

  // first free slot seen during search
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      have_free <= 1'b0;
    end else if (!cmd.new_sta && !rd_valid && !have_free && (scnt != '0)) begin
      have_free <= 1'b1;
      free_sta <= sidx;
    end
  end

  // station record write and read
  always_ff @(posedge clk) begin
    if (rst) sval <= '0;
    else if (cmd.new_sta) sval[free_sta] <= 1'b1;
    if (cmd.new_sta) begin
      skey[free_sta] <= key;
      syoung[free_sta] <= it.time_on_ms;
      sfill[free_sta] <= CW'(1);
      sptr[free_sta] <= (depth > CW'(1)) ? PW'(1) : PW'(0);
    end
    if (cmd.on_commit) begin
      if (it.time_on_ms > young) syoung[cur_sta] <= it.time_on_ms;
      sptr[cur_sta] <= (CW'(wptr_c) + CW'(1) >= depth) ? '0 : wptr_c + PW'(1);
      sfill[cur_sta] <= (fill + CW'(1) > depth) ? depth : fill + CW'(1);
    end
    if (cmd.sta_rd) begin
      cur_sta <= sidx;
      young <= syoung[sidx];
      fill <= (sfill[sidx] > depth) ? depth : sfill[sidx];
      wptr <= sptr[sidx];
    end
  end

  // history memory
  typedef struct packed {
    logic [23:0] comp;
    logic [15:0] loc;
    logic [43:0] on_ms;
    logic [43:0] off_ms;
    logic [31:0] seq;
    logic [31:0] eta;
  } hent_t;
  hent_t hmem [stdf_pkg::MAX_STATIONS * stdf_pkg::HISTORY_DEPTH];
  hent_t hrd;
  logic [CW-1:0] hcnt;

  wire [HW-1:0] hbase_new = HW'(free_sta) * HW'(stdf_pkg::HISTORY_DEPTH);
  wire [HW-1:0] hbase     = HW'(cur_sta) * HW'(stdf_pkg::HISTORY_DEPTH);
  wire [HW-1:0] hrd_addr  = hbase + HW'(hcnt);
  wire hent_t   new_ent   = '{it.comp_code, it.loc_code, it.time_on_ms, it.time_off_ms,
                              it.trig_seq, it.eta_at_on};

  always_ff @(posedge clk) begin
    if (cmd.new_sta) hmem[hbase_new] <= new_ent;
    else if (cmd.on_commit) hmem[hbase + HW'(wptr_c)] <= new_ent;
    else if (cmd.off_write) hmem[hrd_addr] <= '{hrd.comp, hrd.loc, hrd.on_ms,
                                                it.time_off_ms, hrd.seq, hrd.eta};
    if (cmd.hist_rd) hrd <= hmem[hrd_addr];
    if (cmd.sta_rd) hcnt <= '0;
    else if (cmd.hist_adv) hcnt <= hcnt + 1'b1;
  end

  // comparisons on the entry read
  wire [43:0] diff = (it.time_on_ms >= hrd.on_ms) ? it.time_on_ms - hrd.on_ms
                                                  : hrd.on_ms - it.time_on_ms;
  wire [43:0] odt  = young - it.time_on_ms;

  always_comb begin
    stat.comp_ok   = comp_ok;
    stat.is_off    = (it.time_off_ms != '0);
    stat.srch_done = srch_last;
    stat.key_hit   = (rd_key == key);
    stat.sta_valid = rd_valid;
    stat.have_free = have_free || !rd_valid;
    stat.hist_done = (hcnt >= fill);
    stat.off_match = hrd.comp == it.comp_code && hrd.loc == it.loc_code &&
                     hrd.off_ms == '0 && hrd.on_ms == it.time_on_ms &&
                     hrd.seq == it.trig_seq && hrd.eta == it.eta_at_on;
    stat.dup       = diff <= {12'd0, tol};
    stat.too_old   = (omode != stdf_pkg::OMODE_ACCEPT) && (young > it.time_on_ms) &&
                     ((omode == stdf_pkg::OMODE_REJECT) || (odt > {12'd0, olim}));
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (cmd.set_verdict && (cmd.verdict != stdf_pkg::V_ON_PASS)) res_valid <= 1'b1;
    else if (cmd.on_commit) res_valid <= 1'b1;
    else if (out_take) res_valid <= 1'b0;
    if (cmd.set_verdict) res_verdict <= cmd.verdict;
  end
  assign out_busy = res_valid;

  // new station only when a free slot exists
  a_new_free: assert property (@(posedge clk) disable iff (rst)
    cmd.new_sta |-> stat.have_free)
    else $error("new station without free slot");
  a_new_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.new_sta |=> sval[$past(free_sta)])
    else $error("station not marked valid");
  a_commit_pass: assert property (@(posedge clk) disable iff (rst)
    cmd.on_commit |-> res_verdict == stdf_pkg::V_ON_PASS)
    else $error("commit without passed verdict");

endmodule

`default_nettype wire

/* sim/station_trigger_dedup_filter_tb.sv */
`timescale 1ns / 1ps

module station_trigger_dedup_filter_tb;

  localparam int CYCLE_LIMIT = 900000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // site_code, net_code, comp_code, loc_code, time_on_ms, time_off_ms, trig_seq, eta_at_on
  logic [247:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // pass_flag, verdict
  logic [7:0]   m_axis_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [31:0]  cfg_wdata;

  station_trigger_dedup_filter dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  typedef struct {
    logic [39:0] site;
    logic [15:0] net;
    logic [23:0] comp;
    logic [15:0] loc;
    logic [43:0] ton;
    logic [43:0] toff;
    logic [31:0] seq;
    logic [31:0] eta;
  } report_t;

  // filter settings mirrored in the predictor
  logic [31:0] tol_ms;
  logic [1:0]  mode;
  logic [31:0] limit_ms;
  logic [3:0]  hist_len;
  logic [1:0]  acount;
  logic [23:0] allow [3];

  // predictor copy of station table and history
  bit          sta_on [stdf_pkg::MAX_STATIONS];
  logic [55:0] sta_key [stdf_pkg::MAX_STATIONS];
  logic [43:0] sta_young [stdf_pkg::MAX_STATIONS];
  int          sta_fill [stdf_pkg::MAX_STATIONS];
  int          sta_wp [stdf_pkg::MAX_STATIONS];
  report_t     hist [stdf_pkg::MAX_STATIONS * stdf_pkg::HISTORY_DEPTH];

  report_t     pending_words [$];
  logic [2:0]  verdict_q [$];
  int          errors;
  int          cycles;
  logic        quiet;

  // recent reports, replayed to hit off-matches, duplicates and older triggers
  report_t     recent [$];

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  task automatic report_error(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic logic [2:0] predict_verdict(input report_t r);
    logic [55:0] key;
    int depth, found, free_s, base, fill, ptr, e;
    bit ok;
    logic [43:0] d;
    key = {r.site, r.net};
    depth = (hist_len == 0) ? 1 :
            (hist_len > stdf_pkg::HISTORY_DEPTH) ? stdf_pkg::HISTORY_DEPTH : int'(hist_len);
    found = -1;
    free_s = -1;
    if (acount != 0) begin
      ok = 0;
      for (int i = 0; i < acount; i++) if (allow[i] == r.comp) ok = 1;
      if (!ok) return stdf_pkg::V_COMP_REJ;
    end
    for (int s = 0; s < stdf_pkg::MAX_STATIONS; s++) begin
      if (sta_on[s]) begin
        if (found < 0 && sta_key[s] == key) found = s;
      end else if (free_s < 0) begin
        free_s = s;
      end
    end
    if (found < 0) begin
      if (free_s < 0) return stdf_pkg::V_UNTRACKED;
      sta_on[free_s] = 1;
      sta_key[free_s] = key;
      sta_young[free_s] = r.ton;
      sta_fill[free_s] = 1;
      sta_wp[free_s] = (depth > 1) ? 1 : 0;
      hist[free_s * stdf_pkg::HISTORY_DEPTH] = r;
      return stdf_pkg::V_NEW;
    end
    base = found * stdf_pkg::HISTORY_DEPTH;
    fill = (sta_fill[found] > depth) ? depth : sta_fill[found];
    if (r.toff != 0) begin
      for (int i = 0; i < fill; i++) begin
        e = base + i;
        if (hist[e].comp == r.comp && hist[e].loc == r.loc && hist[e].toff == 0 &&
            hist[e].ton == r.ton && hist[e].seq == r.seq && hist[e].eta == r.eta) begin
          hist[e].toff = r.toff;
          return stdf_pkg::V_OFF_MATCH;
        end
      end
      return stdf_pkg::V_OFF_NONE;
    end
    for (int i = 0; i < fill; i++) begin
      d = (r.ton >= hist[base + i].ton) ? r.ton - hist[base + i].ton
                                        : hist[base + i].ton - r.ton;
      if (d <= {12'd0, tol_ms}) return stdf_pkg::V_DUP;
    end
    if (mode != stdf_pkg::OMODE_ACCEPT && sta_young[found] > r.ton) begin
      if (mode == stdf_pkg::OMODE_REJECT) return stdf_pkg::V_OLD;
      if (sta_young[found] - r.ton > {12'd0, limit_ms}) return stdf_pkg::V_OLD;
    end
    if (r.ton > sta_young[found]) sta_young[found] = r.ton;
    ptr = (sta_wp[found] >= depth) ? 0 : sta_wp[found];
    hist[base + ptr] = r;
    sta_wp[found] = (ptr + 1 >= depth) ? 0 : ptr + 1;
    sta_fill[found] = (fill + 1 > depth) ? depth : fill + 1;
    return stdf_pkg::V_ON_PASS;
  endfunction

  // sender: one queued word at a time, random gaps unless quiet
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        verdict_q.push_back(predict_verdict(pending_words.pop_front()));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= 28)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {pending_words[0].eta, pending_words[0].seq, pending_words[0].toff,
                           pending_words[0].ton, pending_words[0].loc, pending_words[0].comp,
                           pending_words[0].net, pending_words[0].site};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls unless quiet, compare with oldest expectation
  always @(posedge clk) begin
    cycles++;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          report_error("result word with nothing expected");
        end else begin
          if (m_axis_tdata[3:1] !== verdict_q[0])
            report_error($sformatf("verdict %0d, expected %0d", m_axis_tdata[3:1], verdict_q[0]));
          if (m_axis_tdata[0] !== (verdict_q[0] <= stdf_pkg::V_OFF_MATCH))
            report_error($sformatf("pass_flag %b for verdict %0d", m_axis_tdata[0], verdict_q[0]));
          if (m_axis_tdata[7:4] !== 4'd0)
            report_error("padding bits not zero");
          void'(verdict_q.pop_front());
        end
      end
      m_axis_tready <= quiet || ($urandom_range(99) >= 28);
    end
  end

  // cycle limit watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL station_trigger_dedup_filter");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      stdf_pkg::REG_TOL:     tol_ms = val;
      stdf_pkg::REG_MODE:    mode = val[1:0];
      stdf_pkg::REG_LIMIT:   limit_ms = val;
      stdf_pkg::REG_HIST:    hist_len = val[3:0];
      stdf_pkg::REG_ACOUNT:  acount = val[1:0];
      stdf_pkg::REG_ALLOW_A: allow[0] = val[23:0];
      stdf_pkg::REG_ALLOW_B: allow[1] = val[23:0];
      stdf_pkg::REG_ALLOW_C: allow[2] = val[23:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every queued word is out and answered, then let the block settle
  task automatic drain();
    while (pending_words.size() != 0 || verdict_q.size() != 0 || s_axis_tvalid)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic report_t random_report(input int nsta);
    report_t r, p;
    int k;
    k = $urandom_range(99);
    if (recent.size() > 0 && k < 55) begin
      p = recent[$urandom_range(recent.size() - 1)];
      r = p;
      case ($urandom_range(4))
        0: r.toff = 44'({$urandom, $urandom}) | 44'd1;               // close it
        1: begin r.toff = 44'({$urandom, $urandom}) | 44'd1; r.seq ^= 32'd1; end
        2: r.ton = p.ton + 44'($urandom_range(40)) - 44'd20;         // near duplicate
        3: begin r.ton = p.ton - 44'($urandom_range(3000)); r.seq = $urandom; end
        default: begin r.ton = p.ton + 44'($urandom_range(5000)); r.seq = $urandom; end
      endcase
    end else begin
      r.site = (k < 90) ? 40'h4142430000 + 40'($urandom_range(nsta - 1))
                        : 40'({$urandom, $urandom});
      r.net  = (k < 90) ? 16'h4e43 : 16'($urandom);
      r.comp = ($urandom_range(1)) ? 24'h48485a + 24'($urandom_range(2)) : 24'($urandom);
      r.loc  = 16'($urandom);
      r.ton  = (k < 95) ? 44'd1000000 + 44'($urandom_range(200000))
                        : 44'({$urandom, $urandom});
      r.toff = '0;
      r.seq  = $urandom;
      r.eta  = $urandom;
    end
    if (recent.size() >= 24) void'(recent.pop_front());
    if (r.toff == 0) recent.push_back(r);
    return r;
  endfunction

  initial begin
    report_t r;
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    tol_ms = 0; mode = 0; limit_ms = 0; hist_len = 8; acount = 0;
    allow[0] = 0; allow[1] = 0; allow[2] = 0;
    for (int s = 0; s < stdf_pkg::MAX_STATIONS; s++) sta_on[s] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, off matching, duplicates, older
    r = '{40'h0, 16'h0, 24'h0, 16'h0, 44'd0, 44'd0, 32'd0, 32'd0};
    pending_words.push_back(r);
    pending_words.push_back(r);                         // duplicate at zero tolerance
    r.toff = 44'hfffffffffff;
    pending_words.push_back(r);                         // closes stored on
    pending_words.push_back(r);                         // nothing open now
    r = '{40'hffffffffff, 16'hffff, 24'hffffff, 16'hffff, 44'hfffffffffff, 44'd0,
          32'hffffffff, 32'h80000000};
    pending_words.push_back(r);
    r.ton = 44'hffffffff000;
    pending_words.push_back(r);                         // older, rejected
    r.ton = 44'd5;
    r.toff = 44'd1;
    pending_words.push_back(r);                         // off unmatched
    drain();

    write_reg(stdf_pkg::REG_TOL, 32'd10);
    write_reg(stdf_pkg::REG_MODE, 32'(stdf_pkg::OMODE_LIMIT));
    write_reg(stdf_pkg::REG_LIMIT, 32'd100);
    write_reg(stdf_pkg::REG_ALLOW_A, 32'h48485a);
    write_reg(stdf_pkg::REG_ALLOW_B, 32'h48484e);
    write_reg(stdf_pkg::REG_ALLOW_C, 32'hffffff);
    write_reg(stdf_pkg::REG_ACOUNT, 32'd3);
    r = '{40'h5354410000, 16'h4e43, 24'h48485a, 16'h3030, 44'd5000, 44'd0, 32'd1, 32'd7};
    pending_words.push_back(r);
    r.ton = 44'd5010; pending_words.push_back(r);       // within tolerance
    r.ton = 44'd5011; pending_words.push_back(r);       // just past tolerance
    r.ton = 44'd4911; r.comp = 24'h48484e; pending_words.push_back(r); // inside limit
    r.ton = 44'd4810; pending_words.push_back(r);       // beyond limit
    r.comp = 24'h454545; pending_words.push_back(r);    // component rejected
    r.comp = 24'hffffff; r.ton = 44'd9000; pending_words.push_back(r);
    drain();

    // fill the station table past capacity
    write_reg(stdf_pkg::REG_ACOUNT, 32'd0);
    write_reg(stdf_pkg::REG_HIST, 32'd0);
    for (int i = 0; i < stdf_pkg::MAX_STATIONS + 2; i++) begin
      r = '{40'h5a00000000 + 40'(i), 16'h5858, 24'h1, 16'h2, 44'd100 + 44'(i), 44'd0,
            32'(i), 32'd0};
      pending_words.push_back(r);
    end
    drain();

    // random phases over several settings; table freed by no reset, so new sites untracked
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin write_reg(stdf_pkg::REG_TOL, 0);
                 write_reg(stdf_pkg::REG_MODE, 32'(stdf_pkg::OMODE_REJECT));
                 write_reg(stdf_pkg::REG_HIST, 8); end
        1: begin write_reg(stdf_pkg::REG_TOL, 5);
                 write_reg(stdf_pkg::REG_MODE, 32'(stdf_pkg::OMODE_LIMIT));
                 write_reg(stdf_pkg::REG_LIMIT, 1000); write_reg(stdf_pkg::REG_HIST, 3); end
        2: begin write_reg(stdf_pkg::REG_MODE, 32'(stdf_pkg::OMODE_ACCEPT));
                 write_reg(stdf_pkg::REG_HIST, 15); end
        3: begin write_reg(stdf_pkg::REG_MODE, 3);
                 write_reg(stdf_pkg::REG_LIMIT, 32'hffffffff);
                 write_reg(stdf_pkg::REG_TOL, 32'hffffffff); end
        4: begin write_reg(stdf_pkg::REG_TOL, 2); write_reg(stdf_pkg::REG_LIMIT, 0);
                 write_reg(stdf_pkg::REG_ACOUNT, 2);
                 write_reg(stdf_pkg::REG_ALLOW_A, 32'h48485a);
                 write_reg(stdf_pkg::REG_ALLOW_B, 32'h48485b);
                 write_reg(stdf_pkg::REG_HIST, 1); end
        5: begin write_reg(stdf_pkg::REG_ACOUNT, 1); write_reg(stdf_pkg::REG_HIST, 8);
                 write_reg(stdf_pkg::REG_MODE, 32'(stdf_pkg::OMODE_REJECT)); end
        default: begin write_reg(stdf_pkg::REG_ACOUNT, 0); write_reg(stdf_pkg::REG_TOL, 20);
                       write_reg(stdf_pkg::REG_MODE, 32'(stdf_pkg::OMODE_LIMIT));
                       write_reg(stdf_pkg::REG_LIMIT, 2000); end
      endcase
      quiet = (ph == 2);
      recent.delete();
      // reuse the first stations so tracking stays reachable
      for (int i = 0; i < 140; i++) begin
        r = random_report(4);
        if ($urandom_range(99) < 75 && r.site[39:8] == 32'h41424300) begin
          r.site = 40'h5a00000000 + 40'($urandom_range(7));
          r.net = 16'h5858;
          if (r.toff == 0 && recent.size() > 0) recent[$] = r;
        end
        pending_words.push_back(r);
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS station_trigger_dedup_filter");
    end else begin
      $display("FAIL station_trigger_dedup_filter");
    end
    $finish;
  end

endmodule
